/* src/whp_pkg.sv */
package whp_pkg;

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_ID,
    PH_FMTLEN,
    PH_DATALEN,
    PH_OTHLEN,
    PH_FMTBODY,
    PH_SKIP,
    PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NOT_RIFF,
    ST_TRUNCATED,
    ST_NOT_WAVE,
    ST_NOT_PCM,
    ST_NO_FMT,
    ST_ZERO_BLOCK
  } status_t;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] PCM_CODE     = 16'd1;

  localparam logic [3:0] HDR_LAST         = 4'd3;
  localparam logic [3:0] FMT_IDX_FORMAT   = 4'd1;
  localparam logic [3:0] FMT_IDX_CHANNELS = 4'd3;
  localparam logic [3:0] FMT_IDX_RATE     = 4'd7;
  localparam logic [3:0] FMT_IDX_DEPTH    = 4'd15;

  localparam int QUO_W     = 32;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

  typedef struct packed {
    logic    shift;
    logic    clear;
    logic    load_chunk;
    logic    load_skip_word;
    logic    load_skip_fmt;
    logic    dec_skip;
    logic    load_chan;
    logic    load_rate;
    logic    load_depth;
    logic    out_load;
    status_t code;
    logic    found;
    logic    div_start;
    logic    div_step;
    logic    div_last;
  } cmd_t;

  typedef struct packed {
    logic is_riff;
    logic is_wave;
    logic is_fmt;
    logic is_data;
    logic word_zero;
    logic pcm_ok;
    logic skip_one;
    logic fmt_short;
    logic block_zero;
  } sts_t;

endpackage

/* src/whp_in_if.sv */
interface whp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* src/whp_out_if.sv */
interface whp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        data_found;
  logic [15:0] chan_count;
  logic [31:0] rate_hz;
  logic [15:0] sample_bits;
  logic [31:0] num_samples;

  modport source (
    output valid, output status, output data_found, output chan_count,
    output rate_hz, output sample_bits, output num_samples, input ready
  );
  modport sink (
    input valid, input status, input data_found, input chan_count,
    input rate_hz, input sample_bits, input num_samples, output ready
  );
endinterface

/* src/whp_ctrl.sv */
module whp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  whp_pkg::sts_t sts,
  output whp_pkg::cmd_t cmd
);

  whp_pkg::phase_t phase, phase_next, phase_adv;
  logic [3:0] field_count, field_count_next, fc_adv;
  logic fmt_seen, fmt_seen_next, fmt_adv;
  logic reported, reported_next, rep_adv;
  logic div_busy, div_busy_next;
  logic [whp_pkg::DIV_CNT_W-1:0] div_count, div_count_next;
  logic out_valid_next;
  logic acc;
  logic show;
  logic finish;
  logic wrap;

  assign in_ready = !div_busy && (!out_valid || out_ready || reported);
  assign acc      = in_valid && in_ready;

  // parse step for the incoming word
  always_comb begin
    phase_adv = phase;
    fc_adv    = field_count;
    fmt_adv   = fmt_seen;
    rep_adv   = reported;
    unique case (phase)
      whp_pkg::PH_RIFF, whp_pkg::PH_RSIZE, whp_pkg::PH_WAVE, whp_pkg::PH_ID,
      whp_pkg::PH_FMTLEN, whp_pkg::PH_DATALEN, whp_pkg::PH_OTHLEN: begin
        if (field_count != whp_pkg::HDR_LAST) begin
          fc_adv = field_count + 4'd1;
        end else begin
          fc_adv = '0;
          unique case (phase)
            whp_pkg::PH_RIFF: begin
              if (sts.is_riff) begin
                phase_adv = whp_pkg::PH_RSIZE;
              end else begin
                phase_adv = whp_pkg::PH_DRAIN;
                rep_adv   = 1'b1;
              end
            end
            whp_pkg::PH_RSIZE: phase_adv = whp_pkg::PH_WAVE;
            whp_pkg::PH_WAVE: begin
              if (sts.is_wave) begin
                phase_adv = whp_pkg::PH_ID;
              end else begin
                phase_adv = whp_pkg::PH_DRAIN;
                rep_adv   = 1'b1;
              end
            end
            whp_pkg::PH_ID: begin
              if (sts.is_fmt) begin
                phase_adv = whp_pkg::PH_FMTLEN;
              end else if (sts.is_data) begin
                phase_adv = whp_pkg::PH_DATALEN;
              end else begin
                phase_adv = whp_pkg::PH_OTHLEN;
              end
            end
            whp_pkg::PH_FMTLEN: phase_adv = whp_pkg::PH_FMTBODY;
            whp_pkg::PH_DATALEN: begin
              phase_adv = whp_pkg::PH_DRAIN;
              rep_adv   = 1'b1;
            end
            whp_pkg::PH_OTHLEN: begin
              phase_adv = sts.word_zero ? whp_pkg::PH_ID : whp_pkg::PH_SKIP;
            end
            default: ;
          endcase
        end
      end
      whp_pkg::PH_FMTBODY: begin
        fc_adv = field_count + 4'd1;
        if (field_count == whp_pkg::FMT_IDX_FORMAT && !sts.pcm_ok) begin
          phase_adv = whp_pkg::PH_DRAIN;
          rep_adv   = 1'b1;
        end else if (field_count == whp_pkg::FMT_IDX_DEPTH) begin
          fc_adv    = '0;
          fmt_adv   = 1'b1;
          phase_adv = sts.fmt_short ? whp_pkg::PH_ID : whp_pkg::PH_SKIP;
        end
      end
      whp_pkg::PH_SKIP: begin
        if (sts.skip_one) begin
          phase_adv = whp_pkg::PH_ID;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    phase_next       = phase;
    field_count_next = field_count;
    fmt_seen_next    = fmt_seen;
    reported_next    = reported;
    if (acc) begin
      if (in_last) begin
        phase_next       = whp_pkg::PH_RIFF;
        field_count_next = '0;
        fmt_seen_next    = 1'b0;
        reported_next    = 1'b0;
      end else begin
        phase_next       = phase_adv;
        field_count_next = fc_adv;
        fmt_seen_next    = fmt_adv;
        reported_next    = rep_adv;
      end
    end

    div_busy_next  = div_busy;
    div_count_next = div_count;
    if (cmd.div_start) begin
      div_busy_next  = 1'b1;
      div_count_next = '0;
    end else if (div_busy) begin
      div_count_next = div_count + 1'b1;
      if (cmd.div_last) begin
        div_busy_next = 1'b0;
      end
    end

    out_valid_next = out_valid;
    if (show) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  // commands
  always_comb begin
    cmd        = '0;
    cmd.shift  = acc;
    cmd.clear  = acc && in_last;
    if (acc) begin
      unique case (phase)
        whp_pkg::PH_FMTLEN, whp_pkg::PH_DATALEN: begin
          cmd.load_chunk = field_count == whp_pkg::HDR_LAST;
        end
        whp_pkg::PH_OTHLEN: begin
          cmd.load_chunk     = field_count == whp_pkg::HDR_LAST;
          cmd.load_skip_word = field_count == whp_pkg::HDR_LAST;
        end
        whp_pkg::PH_FMTBODY: begin
          cmd.load_chan     = field_count == whp_pkg::FMT_IDX_CHANNELS;
          cmd.load_rate     = field_count == whp_pkg::FMT_IDX_RATE;
          cmd.load_depth    = field_count == whp_pkg::FMT_IDX_DEPTH;
          cmd.load_skip_fmt = field_count == whp_pkg::FMT_IDX_DEPTH;
        end
        whp_pkg::PH_SKIP: cmd.dec_skip = 1'b1;
        default: ;
      endcase
    end

    finish = acc && rep_adv && !reported;
    wrap   = acc && in_last && !rep_adv;

    if (finish) begin
      unique case (phase)
        whp_pkg::PH_RIFF:    cmd.code = whp_pkg::ST_NOT_RIFF;
        whp_pkg::PH_WAVE:    cmd.code = whp_pkg::ST_NOT_WAVE;
        whp_pkg::PH_FMTBODY: cmd.code = whp_pkg::ST_NOT_PCM;
        whp_pkg::PH_DATALEN: begin
          if (!fmt_seen) begin
            cmd.code = whp_pkg::ST_NO_FMT;
          end else if (sts.block_zero) begin
            cmd.code = whp_pkg::ST_ZERO_BLOCK;
          end else begin
            cmd.code      = whp_pkg::ST_OK;
            cmd.found     = 1'b1;
            cmd.div_start = 1'b1;
          end
        end
        default: cmd.code = whp_pkg::ST_TRUNCATED;
      endcase
    end else if (wrap) begin
      unique case (phase_adv)
        whp_pkg::PH_RIFF: cmd.code = whp_pkg::ST_NOT_RIFF;
        whp_pkg::PH_WAVE: cmd.code = whp_pkg::ST_NOT_WAVE;
        whp_pkg::PH_ID, whp_pkg::PH_SKIP: begin
          cmd.code = fmt_adv ? whp_pkg::ST_OK : whp_pkg::ST_NO_FMT;
        end
        default: cmd.code = whp_pkg::ST_TRUNCATED;
      endcase
    end

    cmd.out_load = finish || wrap;
    cmd.div_step = div_busy;
    cmd.div_last = div_busy && (div_count == whp_pkg::DIV_LAST);
    show         = (cmd.out_load && !cmd.div_start) || cmd.div_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= whp_pkg::PH_RIFF;
      field_count <= '0;
      fmt_seen    <= 1'b0;
      reported    <= 1'b0;
      div_busy    <= 1'b0;
      div_count   <= '0;
      out_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      field_count <= field_count_next;
      fmt_seen    <= fmt_seen_next;
      reported    <= reported_next;
      div_busy    <= div_busy_next;
      div_count   <= div_count_next;
      out_valid   <= out_valid_next;
    end
  end

endmodule

/* src/whp_datapath.sv */
module whp_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       data_byte,
  input  whp_pkg::cmd_t    cmd,
  output whp_pkg::sts_t    sts,
  output whp_pkg::status_t status,
  output logic             data_found,
  output logic [15:0]      chan_count,
  output logic [31:0]      rate_hz,
  output logic [15:0]      sample_bits,
  output logic [31:0]      num_samples
);

  logic [31:0] shift_word;
  logic [31:0] chunk_length;
  logic [31:0] skip_remaining;
  logic [15:0] channels_held;
  logic [31:0] rate_held;
  logic [15:0] depth_held;

  logic [31:0] word;
  logic [15:0] chan_new;
  logic [31:0] rate_new;
  logic [15:0] depth_new;

  // long division, one quotient bit per cycle
  logic [whp_pkg::QUO_W-1:0] quo;
  logic [28:0] rem;
  logic [28:0] divisor;
  logic [28:0] product;
  logic [29:0] rem_shift;
  logic [29:0] rem_diff;
  logic        ge;

  assign word = {data_byte, shift_word[31:8]};

  assign sts.is_riff    = word == whp_pkg::TAG_RIFF;
  assign sts.is_wave    = word == whp_pkg::TAG_WAVE;
  assign sts.is_fmt     = word == whp_pkg::TAG_FMT;
  assign sts.is_data    = word == whp_pkg::TAG_DATA;
  assign sts.word_zero  = word == '0;
  assign sts.pcm_ok     = word[31:16] == whp_pkg::PCM_CODE;
  assign sts.skip_one   = skip_remaining == 32'd1;
  assign sts.fmt_short  = chunk_length <= whp_pkg::FMT_BODY_LEN;
  assign sts.block_zero = (channels_held == '0) || (depth_held[15:3] == '0);

  assign chan_new  = cmd.load_chan ? word[31:16] : channels_held;
  assign rate_new  = cmd.load_rate ? word : rate_held;
  assign depth_new = cmd.load_depth ? word[31:16] : depth_held;

  assign product   = channels_held * depth_held[15:3];
  assign rem_shift = {rem, quo[whp_pkg::QUO_W-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor};
  assign ge        = rem_shift >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      shift_word     <= '0;
      chunk_length   <= '0;
      skip_remaining <= '0;
      channels_held  <= '0;
      rate_held      <= '0;
      depth_held     <= '0;
    end else begin
      if (cmd.shift) begin
        shift_word <= word;
      end
      if (cmd.load_chunk) begin
        chunk_length <= word;
      end
      if (cmd.load_skip_word) begin
        skip_remaining <= word;
      end else if (cmd.load_skip_fmt) begin
        skip_remaining <= sts.fmt_short ? '0 : chunk_length - whp_pkg::FMT_BODY_LEN;
      end else if (cmd.dec_skip) begin
        skip_remaining <= skip_remaining - 32'd1;
      end
      channels_held <= chan_new;
      rate_held     <= rate_new;
      depth_held    <= depth_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo     <= word;
      rem     <= '0;
      divisor <= product;
    end else if (cmd.div_step) begin
      quo <= {quo[whp_pkg::QUO_W-2:0], ge};
      rem <= ge ? rem_diff[28:0] : rem_shift[28:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= cmd.code;
      data_found  <= cmd.found;
      chan_count  <= chan_new;
      rate_hz     <= rate_new;
      sample_bits <= depth_new;
      num_samples <= '0;
    end else if (cmd.div_last) begin
      num_samples <= {quo[whp_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

/* src/wav_header_parser.sv */
// a result without a divide leaves its register the cycle after the header's last byte
// a data chunk result waits for the bit-serial divide of size by block size
// throughput: one byte per cycle, input held off during the divide
// and at the start of a file while the previous result waits to be taken
// reset: synchronous rst returns the parser to the riff tag and drops any pending result
module wav_header_parser (
  input logic       clk,
  input logic       rst,
  whp_in_if.sink    bytes,
  whp_out_if.source result
);

  whp_pkg::cmd_t    cmd;
  whp_pkg::sts_t    sts;
  whp_pkg::status_t status;

  whp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bytes.valid),
    .in_last   (bytes.last_byte),
    .in_ready  (bytes.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  whp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (bytes.data_byte),
    .cmd         (cmd),
    .sts         (sts),
    .status      (status),
    .data_found  (result.data_found),
    .chan_count  (result.chan_count),
    .rate_hz     (result.rate_hz),
    .sample_bits (result.sample_bits),
    .num_samples (result.num_samples)
  );

  assign result.status = status;

endmodule

/* src/whp_checker.sv */
module whp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic        data_found,
  input logic [15:0] chan_count,
  input logic [31:0] rate_hz,
  input logic [15:0] sample_bits,
  input logic [31:0] num_samples
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_found)
      && $stable(chan_count) && $stable(rate_hz) && $stable(sample_bits)
      && $stable(num_samples))
    else $error("result word changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_found |-> status == 3'd0)
    else $error("data found with error status");

  a_no_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_found |-> num_samples == '0)
    else $error("sample count without data chunk");

endmodule

bind wav_header_parser whp_checker u_whp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .status      (result.status),
  .data_found  (result.data_found),
  .chan_count  (result.chan_count),
  .rate_hz     (result.rate_hz),
  .sample_bits (result.sample_bits),
  .num_samples (result.num_samples)
);
